// ===== src/bpa_pkg.sv =====
// shared types and constants of the buddy page allocator
package bpa_pkg;

    localparam int PAGE_W   = 20;
    localparam int CNT_W    = 13;
    localparam int ORD_W    = 4;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;
    localparam int WIDE_W   = 22;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [WIDE_W-1:0] PAGE_SPACE = WIDE_W'(1) << PAGE_W;

    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OOM_SOFT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_OOM_FATAL = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_PAGE  = 2'd3;

    localparam logic REG_FIRST = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    typedef struct packed {
        logic             free_head;
        logic [ORD_W-1:0] order;
    } t_entry;

endpackage

// ===== src/bpa_in_if.sv =====
// request channel
interface bpa_in_if;
    logic                        valid;
    logic                        ready;
    logic [bpa_pkg::CMD_W-1:0]   cmd;
    logic [bpa_pkg::ORD_W-1:0]   block_order;
    logic [bpa_pkg::PAGE_W-1:0]  page_number;
    logic                        may_fail;
    modport source (output valid, cmd, block_order, page_number, may_fail, input ready);
    modport sink   (input valid, cmd, block_order, page_number, may_fail, output ready);
endinterface

// ===== src/bpa_out_if.sv =====
// response channel
interface bpa_out_if;
    logic                        valid;
    logic                        ready;
    logic [bpa_pkg::STAT_W-1:0]  status;
    logic [bpa_pkg::PAGE_W-1:0]  block_page;
    modport source (output valid, status, block_page, input ready);
    modport sink   (input valid, status, block_page, output ready);
endinterface

// ===== src/buddy_page_allocator_core.sv =====
// buddy page allocator top level: control sequencer, config registers and page store
//
// requests arrive on i_in (cmd, block_order, page_number, may_fail); each request
// gives exactly one response beat on o_out (status, block_page).
// zone registers are written through the apb port: zone_first_page at 0x0,
// zone_page_count at 0x4; write only while no request is in flight.
// one request is worked at a time; i_in.ready is high only when the sequencer idles.
// all free-block state sits in one page store (STORE_DEPTH entries, free flag and order),
// one access per cycle, so the page store port sets the pace of each command:
//   init:  one sweep writing every entry
//   alloc: linear scan of the effective zone, then splits
//   free:  head check, then a read and a write per merge step, then a final write
//   unknown command: straight to the response
// after reset every store entry is swept to zero with i_in.ready low;
// apb writes are taken meanwhile.
// the response sits in an output register; a new request is taken while it waits,
// and the sequencer holds its next response until the receiver takes the old one.
module buddy_page_allocator_core #(
    parameter int STORE_DEPTH = 4096,
    parameter int ORDER_COUNT = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bpa_in_if.sink                        i_in,
    bpa_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpa_pkg::PADDR_W-1:0]   paddr,
    input  logic [bpa_pkg::PDATA_W-1:0]   pwdata,
    output logic [bpa_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int WW  = bpa_pkg::WIDE_W;
    localparam int OW  = bpa_pkg::ORD_W;
    localparam int OBW = OW + 1;
    localparam int EW  = $bits(bpa_pkg::t_entry);
    localparam logic [OBW-1:0] ORD_LIM = OBW'(ORDER_COUNT);

    typedef enum logic [9:0] {
        S_CLR   = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_SCAN  = 10'b0000000100,
        S_SPLIT = 10'b0000001000,
        S_FCHK  = 10'b0000010000,
        S_FHEAD = 10'b0000100000,
        S_MSTEP = 10'b0001000000,
        S_MWAIT = 10'b0010000000,
        S_MFIN  = 10'b0100000000,
        S_RESP  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    logic [bpa_pkg::PAGE_W-1:0] r_first;
    logic [bpa_pkg::CNT_W-1:0]  r_cnt;

    logic [bpa_pkg::CMD_W-1:0]  r_cmd;
    logic [OW-1:0]              r_order;
    logic [bpa_pkg::PAGE_W-1:0] r_page;
    logic                       r_mayf;

    logic              r_carve, n_carve;
    logic [AW-1:0]     r_sweep, n_sweep;
    logic [WW-1:0]     r_next, n_next;
    logic [WW-1:0]     r_n, n_n;
    logic [WW-1:0]     r_ridx, n_ridx;
    logic              r_dv, n_dv;
    logic [AW-1:0]     r_didx, n_didx;
    logic [AW-1:0]     r_best, n_best;
    logic [OBW-1:0]    r_best_o, n_best_o;
    logic [OW-1:0]     r_o, n_o;
    logic [WW-1:0]     r_cur, n_cur;
    logic [bpa_pkg::STAT_W-1:0] r_st, n_st;
    logic [bpa_pkg::PAGE_W-1:0] r_pg, n_pg;

    logic                       r_ov;
    logic [bpa_pkg::STAT_W-1:0] r_ostat;
    logic [bpa_pkg::PAGE_W-1:0] r_opage;

    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    bpa_pkg::t_entry mem_wdata, mem_rdata;

    logic [WW-1:0] eff_n, space, first_w, end_w, abs_pg, sz, bud, half, rel_w;
    logic [OW-1:0] carve_o;
    logic          in_acc, cfg_wr;

    bpa_ram #(.WIDTH(EW), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign in_acc = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == bpa_pkg::REG_COUNT) ?
                    bpa_pkg::PDATA_W'(r_cnt) : bpa_pkg::PDATA_W'(r_first);

    assign o_out.valid      = r_ov;
    assign o_out.status     = r_ostat;
    assign o_out.block_page = r_opage;

    // effective zone size
    always_comb begin
        first_w = WW'(r_first);
        space   = bpa_pkg::PAGE_SPACE - first_w;
        eff_n   = WW'(r_cnt);
        if (eff_n > WW'(STORE_DEPTH)) begin
            eff_n = WW'(STORE_DEPTH);
        end
        if (eff_n > space) begin
            eff_n = space;
        end
        end_w = first_w + r_n;
    end

    // largest aligned block that fits at the sweep position
    always_comb begin
        abs_pg  = first_w + WW'(r_sweep);
        carve_o = '0;
        for (int k = 1; k < ORDER_COUNT; k++) begin
            if ((WW'(r_sweep) + (WW'(1) << k) <= r_n) &&
                ((abs_pg & ((WW'(1) << k) - WW'(1))) == '0)) begin
                carve_o = OW'(k);
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_carve  = r_carve;
        n_sweep  = r_sweep;
        n_next   = r_next;
        n_n      = r_n;
        n_ridx   = r_ridx;
        n_dv     = 1'b0;
        n_didx   = r_didx;
        n_best   = r_best;
        n_best_o = r_best_o;
        n_o      = r_o;
        n_cur    = r_cur;
        n_st     = r_st;
        n_pg     = r_pg;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        sz    = '0;
        bud   = '0;
        half  = '0;
        rel_w = '0;
        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_sweep;
                if (r_carve && (WW'(r_sweep) == r_next) && (r_next < r_n)) begin
                    mem_wdata.free_head = 1'b1;
                    mem_wdata.order     = carve_o;
                    n_next = r_next + (WW'(1) << carve_o);
                end
                n_sweep = r_sweep + AW'(1);
                if (r_sweep == AW'(STORE_DEPTH - 1)) begin
                    n_sweep = '0;
                    n_state = r_carve ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_st   = bpa_pkg::ST_OK;
                    n_pg   = '0;
                    n_n    = eff_n;
                    n_ridx = '0;
                    n_best_o = ORD_LIM;
                    n_best = '0;
                    n_next = '0;
                    n_sweep = '0;
                    case (i_in.cmd)
                        bpa_pkg::CMD_INIT: begin
                            n_carve = 1'b1;
                            n_state = S_CLR;
                        end
                        bpa_pkg::CMD_ALLOC: n_state = S_SCAN;
                        bpa_pkg::CMD_FREE:  n_state = S_FCHK;
                        default:            n_state = S_RESP;
                    endcase
                end
            end
            S_SCAN: begin
                if (OBW'(r_order) >= ORD_LIM) begin
                    n_st    = r_mayf ? bpa_pkg::ST_OOM_SOFT : bpa_pkg::ST_OOM_FATAL;
                    n_state = S_RESP;
                end else begin
                    if (r_dv && mem_rdata.free_head && (mem_rdata.order >= r_order) &&
                        (OBW'(mem_rdata.order) < r_best_o)) begin
                        n_best_o = OBW'(mem_rdata.order);
                        n_best   = r_didx;
                    end
                    if (r_ridx < r_n) begin
                        mem_re    = 1'b1;
                        mem_raddr = r_ridx[AW-1:0];
                        n_dv      = 1'b1;
                        n_didx    = r_ridx[AW-1:0];
                        n_ridx    = r_ridx + WW'(1);
                    end else if (!r_dv) begin
                        if (r_best_o >= ORD_LIM) begin
                            n_st = r_mayf ? bpa_pkg::ST_OOM_SOFT : bpa_pkg::ST_OOM_FATAL;
                            n_state = S_RESP;
                        end else begin
                            n_o     = r_best_o[OW-1:0];
                            n_state = S_SPLIT;
                        end
                    end
                end
            end
            S_SPLIT: begin
                if (r_o > r_order) begin
                    n_o  = r_o - OW'(1);
                    half = WW'(r_best) + (WW'(1) << n_o);
                    if (half < WW'(STORE_DEPTH)) begin
                        mem_we    = 1'b1;
                        mem_waddr = half[AW-1:0];
                        mem_wdata.free_head = 1'b1;
                        mem_wdata.order     = n_o;
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_best;
                    n_pg      = bpa_pkg::PAGE_W'(first_w + WW'(r_best));
                    n_state   = S_RESP;
                end
            end
            S_FCHK: begin
                sz    = WW'(1) << r_order;
                rel_w = WW'(r_page) - first_w;
                if ((OBW'(r_order) >= ORD_LIM) || (WW'(r_page) < first_w) ||
                    (WW'(r_page) >= end_w) || ((WW'(r_page) & (sz - WW'(1))) != '0) ||
                    (WW'(r_page) + sz > end_w)) begin
                    n_st    = bpa_pkg::ST_BAD_PAGE;
                    n_state = S_RESP;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = rel_w[AW-1:0];
                    n_cur     = WW'(r_page);
                    n_o       = r_order;
                    n_state   = S_FHEAD;
                end
            end
            S_FHEAD: begin
                n_state = mem_rdata.free_head ? S_RESP : S_MSTEP;
            end
            S_MSTEP: begin
                sz  = WW'(1) << r_o;
                bud = r_cur ^ sz;
                rel_w = bud - first_w;
                if ((OBW'(r_o) + OBW'(1) >= ORD_LIM) || (bud < first_w) ||
                    (bud + sz > end_w)) begin
                    n_state = S_MFIN;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = rel_w[AW-1:0];
                    n_state   = S_MWAIT;
                end
            end
            S_MWAIT: begin
                sz  = WW'(1) << r_o;
                bud = r_cur ^ sz;
                rel_w = bud - first_w;
                if (!mem_rdata.free_head || (mem_rdata.order != r_o)) begin
                    n_state = S_MFIN;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = rel_w[AW-1:0];
                    if (bud < r_cur) begin
                        n_cur = bud;
                    end
                    n_o     = r_o + OW'(1);
                    n_state = S_MSTEP;
                end
            end
            S_MFIN: begin
                rel_w     = r_cur - first_w;
                mem_we    = 1'b1;
                mem_waddr = rel_w[AW-1:0];
                mem_wdata.free_head = 1'b1;
                mem_wdata.order     = r_o;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (!r_ov || o_out.ready) begin
                    n_carve = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_carve <= 1'b0;
            r_sweep <= '0;
            r_dv    <= 1'b0;
            r_ov    <= 1'b0;
            r_first <= '0;
            r_cnt   <= bpa_pkg::CNT_W'(4096);
        end else begin
            r_state <= n_state;
            r_carve <= n_carve;
            r_sweep <= n_sweep;
            r_dv    <= n_dv;
            if (cfg_wr) begin
                if (paddr[2] == bpa_pkg::REG_FIRST) begin
                    r_first <= pwdata[bpa_pkg::PAGE_W-1:0];
                end else begin
                    r_cnt <= pwdata[bpa_pkg::CNT_W-1:0];
                end
            end
            if (r_state == S_RESP && (!r_ov || o_out.ready)) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_next   <= n_next;
        r_n      <= n_n;
        r_ridx   <= n_ridx;
        r_didx   <= n_didx;
        r_best   <= n_best;
        r_best_o <= n_best_o;
        r_o      <= n_o;
        r_cur    <= n_cur;
        r_st     <= n_st;
        r_pg     <= n_pg;
        if (in_acc) begin
            r_cmd   <= i_in.cmd;
            r_order <= i_in.block_order;
            r_page  <= i_in.page_number;
            r_mayf  <= i_in.may_fail;
        end
        if (r_state == S_RESP && (!r_ov || o_out.ready)) begin
            r_ostat <= r_st;
            r_opage <= r_pg;
        end
    end

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("sequencer state not one-hot");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE)) else $error("request accepted but sequencer idle");

    a_beat_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_RESP)) else $error("response beat without resp");

    a_one_port_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re)) else $error("page store read and write in one cycle");

    a_cmd_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT) |-> (r_cmd == bpa_pkg::CMD_ALLOC))
        else $error("split outside alloc");
endmodule

// ===== src/bpa_ram.sv =====
// generic single write port ram with registered read
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sim/tb_buddy_page_allocator_core.sv =====
// testbench of the buddy page allocator: random and directed requests checked against a predictor
module tb_buddy_page_allocator_core;

    localparam int NPG = 4096;
    localparam int NORD = 11;
    localparam int WDOG_LIMIT = 60000;
    localparam logic [bpa_pkg::CMD_W-1:0]   CMD_UNUSED = 2'd3;
    localparam logic [bpa_pkg::PADDR_W-1:0] ADDR_FIRST = 3'd0;
    localparam logic [bpa_pkg::PADDR_W-1:0] ADDR_COUNT = 3'd4;

    class alloc_scoreboard;
        logic [bpa_pkg::PAGE_W-1:0] first_page;
        logic [bpa_pkg::CNT_W-1:0]  page_count;
        bit                         head [NPG];
        logic [bpa_pkg::ORD_W-1:0]  ord [NPG];
        logic [bpa_pkg::STAT_W-1:0] exp_status [$];
        logic [bpa_pkg::PAGE_W-1:0] exp_page [$];
        int                         errors;

        function new();
            first_page = '0;
            page_count = 13'd4096;
            errors = 0;
            foreach (head[i]) begin
                head[i] = 1'b0;
                ord[i] = '0;
            end
        endfunction

        function int zone_size();
            int n;
            n = int'(page_count);
            if (n > NPG) n = NPG;
            if (n > 32'h100000 - int'(first_page)) n = 32'h100000 - int'(first_page);
            return n;
        endfunction

        function void carve();
            int n, rel, o;
            n = zone_size();
            foreach (head[i]) begin
                head[i] = 1'b0;
                ord[i] = '0;
            end
            rel = 0;
            while (rel < n) begin
                o = NORD - 1;
                while (o > 0) begin
                    if (rel + (1 << o) <= n &&
                        ((int'(first_page) + rel) & ((1 << o) - 1)) == 0)
                        break;
                    o--;
                end
                head[rel] = 1'b1;
                ord[rel] = bpa_pkg::ORD_W'(o);
                rel += 1 << o;
            end
        endfunction

        function bit take(int order, output logic [bpa_pkg::PAGE_W-1:0] pg);
            int n, best, best_o;
            n = zone_size();
            best = 0;
            best_o = NORD;
            pg = '0;
            if (order >= NORD) return 0;
            for (int r = 0; r < n; r++)
                if (head[r] && int'(ord[r]) >= order && int'(ord[r]) < best_o) begin
                    best_o = int'(ord[r]);
                    best = r;
                end
            if (best_o >= NORD) return 0;
            while (best_o > order) begin
                best_o--;
                if (best + (1 << best_o) < NPG) begin
                    head[best + (1 << best_o)] = 1'b1;
                    ord[best + (1 << best_o)] = bpa_pkg::ORD_W'(best_o);
                end
            end
            head[best] = 1'b0;
            ord[best] = '0;
            pg = bpa_pkg::PAGE_W'(int'(first_page) + best);
            return 1;
        endfunction

        function logic [bpa_pkg::STAT_W-1:0] give_back(int order, longint pg);
            longint first, last, cur, bud, sz;
            int o;
            first = longint'(first_page);
            last = first + zone_size();
            if (order >= NORD) return bpa_pkg::ST_BAD_PAGE;
            if (pg < first || pg >= last) return bpa_pkg::ST_BAD_PAGE;
            if ((pg & ((64'd1 << order) - 1)) != 0) return bpa_pkg::ST_BAD_PAGE;
            if (pg + (64'd1 << order) > last) return bpa_pkg::ST_BAD_PAGE;
            if (head[pg - first]) return bpa_pkg::ST_OK;
            cur = pg;
            o = order;
            while (o + 1 < NORD) begin
                sz = 64'd1 << o;
                bud = cur ^ sz;
                if (bud < first || bud + sz > last) break;
                if (!head[bud - first] || int'(ord[bud - first]) != o) break;
                head[bud - first] = 1'b0;
                ord[bud - first] = '0;
                if (bud < cur) cur = bud;
                o++;
            end
            head[cur - first] = 1'b1;
            ord[cur - first] = bpa_pkg::ORD_W'(o);
            return bpa_pkg::ST_OK;
        endfunction

        function void note_request(logic [bpa_pkg::CMD_W-1:0] cmd,
                                   logic [bpa_pkg::ORD_W-1:0] order,
                                   logic [bpa_pkg::PAGE_W-1:0] pg, logic fail_ok);
            logic [bpa_pkg::STAT_W-1:0] st;
            logic [bpa_pkg::PAGE_W-1:0] blk;
            st = bpa_pkg::ST_OK;
            blk = '0;
            if (cmd == bpa_pkg::CMD_INIT) carve();
            else if (cmd == bpa_pkg::CMD_ALLOC) begin
                if (!take(int'(order), blk))
                    st = fail_ok ? bpa_pkg::ST_OOM_SOFT : bpa_pkg::ST_OOM_FATAL;
            end else if (cmd == bpa_pkg::CMD_FREE) st = give_back(int'(order), longint'(pg));
            exp_status.push_back(st);
            exp_page.push_back(blk);
        endfunction

        function void check_response(logic [bpa_pkg::STAT_W-1:0] st,
                                     logic [bpa_pkg::PAGE_W-1:0] blk);
            logic [bpa_pkg::STAT_W-1:0] es;
            logic [bpa_pkg::PAGE_W-1:0] ep;
            if (exp_status.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat: status %0d page %0h", st, blk);
                return;
            end
            es = exp_status.pop_front();
            ep = exp_page.pop_front();
            if (st !== es || blk !== ep) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: status exp %0d got %0d, page exp %0h got %0h",
                             es, st, ep, blk);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite;
    logic [bpa_pkg::PADDR_W-1:0] paddr;
    logic [bpa_pkg::PDATA_W-1:0] pwdata, prdata;
    logic pready;
    int send_idle, recv_stall, wdog;
    bit timed_out;

    bpa_in_if  req_if ();
    bpa_out_if rsp_if ();

    buddy_page_allocator_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(req_if.sink), .o_out(rsp_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    alloc_scoreboard sb = new();
    logic [bpa_pkg::PAGE_W-1:0] owned_page [$];
    logic [bpa_pkg::ORD_W-1:0]  owned_ord [$];

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        req_if.valid = 0; req_if.cmd = '0; req_if.block_order = '0;
        req_if.page_number = '0; req_if.may_fail = 0;
        rsp_if.ready = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall);
            if (rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.status, rsp_if.block_page);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
                || psel)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("tb_buddy_page_allocator_core: FAIL");
            $finish;
        end
    end

    task automatic reg_write(logic [bpa_pkg::PADDR_W-1:0] addr,
                             logic [bpa_pkg::PDATA_W-1:0] data);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (addr == ADDR_FIRST) sb.first_page = data[bpa_pkg::PAGE_W-1:0];
        else sb.page_count = data[bpa_pkg::CNT_W-1:0];
    endtask

    task automatic send(logic [bpa_pkg::CMD_W-1:0] cmd, logic [bpa_pkg::ORD_W-1:0] order,
                        logic [bpa_pkg::PAGE_W-1:0] pg, logic fail_ok);
        while ($urandom_range(99) < send_idle) begin
            req_if.valid <= 0;
            @(posedge i_clk);
        end
        req_if.valid <= 1; req_if.cmd <= cmd; req_if.block_order <= order;
        req_if.page_number <= pg; req_if.may_fail <= fail_ok;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(cmd, order, pg, fail_ok);
        if (cmd == bpa_pkg::CMD_ALLOC && sb.exp_status[$] == bpa_pkg::ST_OK) begin
            owned_page.push_back(sb.exp_page[$]);
            owned_ord.push_back(order);
        end
    endtask

    task automatic drain();
        req_if.valid <= 0;
        while (sb.exp_status.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic random_traffic(int count);
        int k, pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 45)
                send(bpa_pkg::CMD_ALLOC,
                     bpa_pkg::ORD_W'(($urandom_range(9) < 8) ? $urandom_range(4)
                                                              : $urandom_range(15)),
                     bpa_pkg::PAGE_W'($urandom), 1'($urandom_range(1)));
            else if (pick < 85 && owned_page.size() != 0) begin
                k = $urandom_range(owned_page.size() - 1);
                send(bpa_pkg::CMD_FREE, owned_ord[k], owned_page[k], 1'($urandom_range(1)));
                owned_page.delete(k);
                owned_ord.delete(k);
            end else if (pick < 95)
                send(bpa_pkg::CMD_FREE, bpa_pkg::ORD_W'($urandom_range(15)),
                     bpa_pkg::PAGE_W'(sb.first_page + $urandom_range(4200)),
                     1'($urandom_range(1)));
            else if (pick < 97)
                send(bpa_pkg::CMD_FREE, bpa_pkg::ORD_W'($urandom_range(15)),
                     bpa_pkg::PAGE_W'($urandom), 1'($urandom_range(1)));
            else if (pick < 98)
                send(CMD_UNUSED, bpa_pkg::ORD_W'($urandom), bpa_pkg::PAGE_W'($urandom),
                     1'($urandom_range(1)));
            else begin
                send(bpa_pkg::CMD_INIT, bpa_pkg::ORD_W'($urandom),
                     bpa_pkg::PAGE_W'($urandom), 1'($urandom_range(1)));
                owned_page.delete();
                owned_ord.delete();
            end
        end
    endtask

    task automatic new_zone(logic [bpa_pkg::PAGE_W-1:0] first,
                            logic [bpa_pkg::CNT_W-1:0] cnt);
        drain();
        reg_write(ADDR_FIRST, bpa_pkg::PDATA_W'(first));
        reg_write(ADDR_COUNT, bpa_pkg::PDATA_W'(cnt));
        owned_page.delete();
        owned_ord.delete();
        send(bpa_pkg::CMD_INIT, '0, '0, 1'b0);
    endtask

    initial begin
        send_idle = 0;
        recv_stall = 0;
        timed_out = 0;
        wdog = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // no init yet: allocs fail, and an unknown command still gets a response
        send(bpa_pkg::CMD_ALLOC, 4'd0, '0, 1'b1);
        send(bpa_pkg::CMD_ALLOC, 4'd0, '0, 1'b0);
        send(CMD_UNUSED, 4'hf, 20'hfffff, 1'b1);
        new_zone(20'd0, 13'd16);
        send(bpa_pkg::CMD_ALLOC, 4'd0, 20'hfffff, 1'b0);
        send(bpa_pkg::CMD_ALLOC, 4'd1, '0, 1'b0);
        send(bpa_pkg::CMD_ALLOC, 4'd2, '0, 1'b0);
        send(bpa_pkg::CMD_ALLOC, 4'd3, '0, 1'b1);
        send(bpa_pkg::CMD_ALLOC, 4'd11, '0, 1'b1);
        send(bpa_pkg::CMD_ALLOC, 4'hf, '0, 1'b0);
        send(bpa_pkg::CMD_FREE, 4'd0, 20'd0, 1'b0);
        send(bpa_pkg::CMD_FREE, 4'd0, 20'd0, 1'b0);
        send(bpa_pkg::CMD_FREE, 4'd1, 20'd1, 1'b0);
        send(bpa_pkg::CMD_FREE, 4'd11, 20'd0, 1'b0);
        send(bpa_pkg::CMD_FREE, 4'd3, 20'd8, 1'b0);
        send(bpa_pkg::CMD_FREE, 4'd0, 20'hfffff, 1'b1);
        send(bpa_pkg::CMD_FREE, 4'd1, 20'd2, 1'b1);
        send(bpa_pkg::CMD_FREE, 4'd2, 20'd4, 1'b1);
        send(bpa_pkg::CMD_FREE, 4'd5, 20'd0, 1'b1);
        new_zone(20'hffff3, 13'h1fff);
        send(bpa_pkg::CMD_ALLOC, 4'd2, '0, 1'b1);
        send(bpa_pkg::CMD_ALLOC, 4'd10, '0, 1'b1);
        send(bpa_pkg::CMD_FREE, 4'd0, 20'hfffff, 1'b1);
        new_zone(20'd0, 13'd4096);
        random_traffic(200);
        new_zone(20'h12345, 13'd0);
        random_traffic(20);
        new_zone(20'h00805, 13'd300);
        random_traffic(300);
        send_idle = 67;
        new_zone(20'haaaa3, 13'd100);
        random_traffic(300);
        drain();
        recv_stall = 67;
        send_idle = 0;
        random_traffic(300);
        send_idle = 30;
        recv_stall = 30;
        new_zone(20'h5555c, 13'd77);
        random_traffic(300);
        send_idle = 0;
        recv_stall = 0;
        random_traffic(100);
        drain();
        if (sb.errors == 0 && sb.exp_status.size() == 0)
            $display("tb_buddy_page_allocator_core: PASS");
        else
            $display("tb_buddy_page_allocator_core: FAIL");
        $finish;
    end
endmodule
